// File: rtl/core/sme_pkg.sv
`default_nettype none

package sme_pkg;

  localparam int ACT_W         = 8;
  localparam int DATA_W        = 32;
  localparam int PC_W          = 13;
  localparam int ST_W          = 3;

  localparam int STACK_DEPTH   = 64;
  localparam int STK_AW        = $clog2(STACK_DEPTH);
  localparam int CNT_W         = STK_AW + 1;

  localparam int VAR_COUNT     = 256;
  localparam int VAR_AW        = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;

  localparam int PROGRAM_DEPTH = 4096;

  localparam logic [ACT_W-1:0] OP_PUSH    = 8'h01;
  localparam logic [ACT_W-1:0] OP_LOAD    = 8'h02;
  localparam logic [ACT_W-1:0] OP_STORE   = 8'h03;
  localparam logic [ACT_W-1:0] OP_ADD     = 8'h04;
  localparam logic [ACT_W-1:0] OP_LESS    = 8'h05;
  localparam logic [ACT_W-1:0] OP_JUMP_IF = 8'h06;
  localparam logic [ACT_W-1:0] OP_PRINT   = 8'h07;
  localparam logic [ACT_W-1:0] OP_JUMP    = 8'h08;
  localparam logic [ACT_W-1:0] OP_HALT    = 8'hFF;

  localparam logic [ST_W-1:0] ST_OK         = 3'd0;
  localparam logic [ST_W-1:0] ST_UNDERFLOW  = 3'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW   = 3'd2;
  localparam logic [ST_W-1:0] ST_BAD_INDEX  = 3'd3;
  localparam logic [ST_W-1:0] ST_BAD_OPCODE = 3'd4;
  localparam logic [ST_W-1:0] ST_BAD_JUMP   = 3'd5;

  typedef struct packed {
    logic [PC_W-1:0]   pc;
    logic [CNT_W-1:0]  cnt;
    logic [DATA_W-1:0] top;
    logic              halt;
  } state_t;

  typedef struct packed {
    logic [PC_W-1:0]   next_pc;
    logic              print_valid;
    logic [DATA_W-1:0] print_value;
    logic              halted;
    logic              ran_off_end;
    logic [ST_W-1:0]   status;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [STK_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } stk_wr_t;

  typedef struct packed {
    logic              en;
    logic [VAR_AW-1:0] addr;
    logic [DATA_W-1:0] data;
  } var_wr_t;

endpackage

`default_nettype wire

// File: rtl/core/sme_if.sv
`default_nettype none

interface sme_in_if;
  logic                               valid;
  logic                               ready;
  logic [sme_pkg::ACT_W-1:0]          action;
  logic signed [sme_pkg::DATA_W-1:0]  operand_value;

  modport source(output valid, action, operand_value, input ready);
  modport sink(input valid, action, operand_value, output ready);
endinterface

interface sme_out_if;
  logic                               valid;
  logic                               ready;
  logic [sme_pkg::PC_W-1:0]           next_pc;
  logic                               print_valid;
  logic signed [sme_pkg::DATA_W-1:0]  print_value;
  logic                               halted;
  logic                               ran_off_end;
  logic [sme_pkg::ST_W-1:0]           status;

  modport source(output valid, next_pc, print_valid, print_value, halted, ran_off_end,
                 status, input ready);
  modport sink(input valid, next_pc, print_valid, print_value, halted, ran_off_end,
               status, output ready);
endinterface

interface sme_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [sme_pkg::PC_W-1:0]  program_length;

  modport source(output valid, program_length, input ready);
  modport sink(input valid, program_length, output ready);
endinterface

`default_nettype wire

// File: rtl/core/stack_machine_execute_unit_core.sv
`default_nettype none

// Executes one bytecode instruction per transfer on in_ch and returns exactly one result
// per instruction on out_ch. A new instruction is taken in every cycle unless out_ch
// stalls; an instruction passes through the input register, then the result register,
// which drives out_ch, and out_ch may stall while the next instruction waits in the
// input register. The top of the operand stack lives in a register and the entry below
// it is prefetched from the stack RAM into a register, so no instruction waits on the
// stack. The variable file is read at the input transfer, with bypass from a store
// executing in that same cycle; each entry carries a valid bit, so it reads as zero
// after reset without any clearing pass.
// Write program_length through cfg_ch only while no instruction is in flight.
module stack_machine_execute_unit_core (
  input  var logic     clk,
  input  var logic     rst_n,
  sme_in_if.sink       in_ch,
  sme_out_if.source    out_ch,
  sme_cfg_if.sink      cfg_ch
);

  sme_pkg::state_t                   st_r;
  sme_pkg::state_t                   st_exec;
  sme_pkg::state_t                   st_nxt;
  sme_pkg::result_t                  res_exec;
  sme_pkg::result_t                  res_r;
  sme_pkg::stk_wr_t                  stk_wr;
  sme_pkg::var_wr_t                  var_wr;

  logic [sme_pkg::PC_W-1:0]          len_r;
  logic                              in_valid_r;
  logic [sme_pkg::ACT_W-1:0]         act_r;
  logic [sme_pkg::DATA_W-1:0]        opnd_r;
  logic                              out_valid_r;

  logic                              in_fire;
  logic                              exec_fire;
  logic                              stk_we;
  logic                              var_we;

  logic [sme_pkg::DATA_W-1:0]        stk_mem [sme_pkg::STACK_DEPTH];
  logic [sme_pkg::DATA_W-1:0]        stk_rdata_r;
  logic [sme_pkg::CNT_W-1:0]         stk_rptr;

  logic [sme_pkg::DATA_W-1:0]        var_mem [sme_pkg::VAR_COUNT];
  logic [sme_pkg::VAR_COUNT-1:0]     var_vld_r;
  logic [sme_pkg::VAR_AW-1:0]        var_raddr;
  logic [sme_pkg::DATA_W-1:0]        var_rdata_r;
  logic                              var_rvld_r;
  logic                              var_hit_r;
  logic [sme_pkg::DATA_W-1:0]        var_fwd_r;
  logic [sme_pkg::DATA_W-1:0]        var_val;

  assign exec_fire    = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready  = !in_valid_r || exec_fire;
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign var_val = var_hit_r ? var_fwd_r : (var_rvld_r ? var_rdata_r : '0);

  sme_exec u_exec (
    .st      (st_r),
    .action  (act_r),
    .opnd    (opnd_r),
    .stk_nos (stk_rdata_r),
    .var_val (var_val),
    .len     (len_r),
    .st_nxt  (st_exec),
    .res     (res_exec),
    .stk_wr  (stk_wr),
    .var_wr  (var_wr)
  );

  assign st_nxt    = exec_fire ? st_exec : st_r;
  assign stk_we    = exec_fire && stk_wr.en;
  assign var_we    = exec_fire && var_wr.en;
  assign stk_rptr  = st_nxt.cnt - sme_pkg::CNT_W'(2);
  assign var_raddr = in_ch.operand_value[sme_pkg::VAR_AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      len_r       <= '0;
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_ch.valid) begin
        len_r <= (cfg_ch.program_length > sme_pkg::PC_W'(sme_pkg::PROGRAM_DEPTH))
                 ? sme_pkg::PC_W'(sme_pkg::PROGRAM_DEPTH) : cfg_ch.program_length;
      end
      if (in_fire) begin
        in_valid_r <= 1'b1;
      end else if (exec_fire) begin
        in_valid_r <= 1'b0;
      end
      if (exec_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_r  <= in_ch.action;
      opnd_r <= in_ch.operand_value;
    end
    if (exec_fire) begin
      res_r <= res_exec;
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_wr.addr] <= stk_wr.data;
    end
    stk_rdata_r <= stk_mem[stk_rptr[sme_pkg::STK_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (var_we) begin
      var_mem[var_wr.addr] <= var_wr.data;
    end
    if (in_fire) begin
      var_rdata_r <= var_mem[var_raddr];
      var_rvld_r  <= var_vld_r[var_raddr];
      var_hit_r   <= var_we && (var_wr.addr == var_raddr);
      var_fwd_r   <= var_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      var_vld_r <= '0;
    end else if (var_we) begin
      var_vld_r[var_wr.addr] <= 1'b1;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.next_pc     = res_r.next_pc;
  assign out_ch.print_valid = res_r.print_valid;
  assign out_ch.print_value = res_r.print_value;
  assign out_ch.halted      = res_r.halted;
  assign out_ch.ran_off_end = res_r.ran_off_end;
  assign out_ch.status      = res_r.status;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.cnt <= sme_pkg::CNT_W'(sme_pkg::STACK_DEPTH))
    else $error("operand stack count exceeds its depth");

  a_halt_holds: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halt |=> st_r.halt && $stable(st_r.pc) && $stable(st_r.cnt))
    else $error("machine state changed after halt");

  a_idle_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (exec_fire && (st_r.halt || st_r.pc >= len_r))
      |=> $stable(st_r.pc) && $stable(st_r.cnt) && $stable(st_r.halt))
    else $error("instruction executed while not running");

  a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && !exec_fire) |=> in_valid_r)
    else $error("pending instruction dropped without execution");

endmodule

`default_nettype wire

// File: rtl/core/sme_exec.sv
`default_nettype none

module sme_exec (
  input  var sme_pkg::state_t                st,
  input  var logic [sme_pkg::ACT_W-1:0]      action,
  input  var logic [sme_pkg::DATA_W-1:0]     opnd,
  input  var logic [sme_pkg::DATA_W-1:0]     stk_nos,
  input  var logic [sme_pkg::DATA_W-1:0]     var_val,
  input  var logic [sme_pkg::PC_W-1:0]       len,
  output sme_pkg::state_t                    st_nxt,
  output sme_pkg::result_t                   res,
  output sme_pkg::stk_wr_t                   stk_wr,
  output sme_pkg::var_wr_t                   var_wr
);

  logic                         run;
  logic [sme_pkg::PC_W-1:0]     npc;
  logic [sme_pkg::ST_W-1:0]     status;
  logic [sme_pkg::CNT_W-1:0]    cnt_p1;
  logic [sme_pkg::CNT_W-1:0]    cnt_m1;
  logic [sme_pkg::CNT_W-1:0]    cnt_m2;
  logic                         full;
  logic                         index_ok;
  logic                         target_ok;
  logic [sme_pkg::DATA_W-1:0]   sum;
  logic                         less;

  assign run       = !st.halt && (st.pc < len);
  assign cnt_p1    = st.cnt + sme_pkg::CNT_W'(1);
  assign cnt_m1    = st.cnt - sme_pkg::CNT_W'(1);
  assign cnt_m2    = st.cnt - sme_pkg::CNT_W'(2);
  assign full      = st.cnt >= sme_pkg::CNT_W'(sme_pkg::STACK_DEPTH);
  assign index_ok  = opnd < sme_pkg::DATA_W'(sme_pkg::VAR_COUNT);
  assign target_ok = opnd <= sme_pkg::DATA_W'(len);
  assign sum       = stk_nos + st.top;
  assign less      = $signed(stk_nos) < $signed(st.top);

  always_comb begin
    st_nxt = st;
    npc    = st.pc;
    status = sme_pkg::ST_OK;
    res    = '0;
    stk_wr = '0;
    var_wr = '0;
    if (run) begin
      npc = st.pc + sme_pkg::PC_W'(1);
      case (action)
        sme_pkg::OP_PUSH: begin
          if (full) begin
            status = sme_pkg::ST_OVERFLOW;
          end else begin
            st_nxt.top  = opnd;
            st_nxt.cnt  = cnt_p1;
            stk_wr.en   = 1'b1;
            stk_wr.addr = st.cnt[sme_pkg::STK_AW-1:0];
            stk_wr.data = opnd;
          end
        end
        sme_pkg::OP_LOAD: begin
          if (!index_ok) begin
            status = sme_pkg::ST_BAD_INDEX;
          end else if (full) begin
            status = sme_pkg::ST_OVERFLOW;
          end else begin
            st_nxt.top  = var_val;
            st_nxt.cnt  = cnt_p1;
            stk_wr.en   = 1'b1;
            stk_wr.addr = st.cnt[sme_pkg::STK_AW-1:0];
            stk_wr.data = var_val;
          end
        end
        sme_pkg::OP_STORE: begin
          if (st.cnt != '0) begin
            if (!index_ok) begin
              status = sme_pkg::ST_BAD_INDEX;
            end else begin
              var_wr.en   = 1'b1;
              var_wr.addr = opnd[sme_pkg::VAR_AW-1:0];
              var_wr.data = st.top;
              st_nxt.top  = stk_nos;
              st_nxt.cnt  = cnt_m1;
            end
          end
        end
        sme_pkg::OP_ADD, sme_pkg::OP_LESS: begin
          if (st.cnt < sme_pkg::CNT_W'(2)) begin
            status = sme_pkg::ST_UNDERFLOW;
          end else begin
            st_nxt.top  = (action == sme_pkg::OP_ADD) ? sum
                                                      : sme_pkg::DATA_W'(less);
            st_nxt.cnt  = cnt_m1;
            stk_wr.en   = 1'b1;
            stk_wr.addr = cnt_m2[sme_pkg::STK_AW-1:0];
            stk_wr.data = st_nxt.top;
          end
        end
        sme_pkg::OP_JUMP_IF: begin
          if (st.cnt == '0) begin
            status = sme_pkg::ST_UNDERFLOW;
          end else if (st.top != '0) begin
            if (!target_ok) begin
              status = sme_pkg::ST_BAD_JUMP;
            end else begin
              st_nxt.top = stk_nos;
              st_nxt.cnt = cnt_m1;
              npc        = opnd[sme_pkg::PC_W-1:0];
            end
          end else begin
            st_nxt.top = stk_nos;
            st_nxt.cnt = cnt_m1;
          end
        end
        sme_pkg::OP_JUMP: begin
          if (!target_ok) begin
            status = sme_pkg::ST_BAD_JUMP;
          end else begin
            npc = opnd[sme_pkg::PC_W-1:0];
          end
        end
        sme_pkg::OP_PRINT: begin
          if (st.cnt == '0) begin
            status = sme_pkg::ST_UNDERFLOW;
          end else begin
            res.print_valid = 1'b1;
            res.print_value = st.top;
            st_nxt.top      = stk_nos;
            st_nxt.cnt      = cnt_m1;
          end
        end
        sme_pkg::OP_HALT: begin
          st_nxt.halt = 1'b1;
          npc         = st.pc;
        end
        default: begin
          status = sme_pkg::ST_BAD_OPCODE;
        end
      endcase
    end
    st_nxt.pc       = npc;
    res.next_pc     = npc;
    res.halted      = st_nxt.halt;
    res.ran_off_end = npc >= len;
    res.status      = status;
  end

endmodule

`default_nettype wire
